>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the local clock, off while reset is asserted
`define HMSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition in one cycle implies consequence in the next
`define HMSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  `HMSC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> hw/rtl/hmsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hmsc_pkg;

  // fixed field widths
  localparam int unsigned TILE_W    = 6;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned SRC_W     = 8;
  localparam int unsigned Z_W       = 17;
  localparam int unsigned HEIGHT_W  = 16;
  localparam int unsigned CAP_W     = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IN_DATA_W = 64;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 16'hffff;
  localparam logic [CAP_W-1:0]    CAP_MAX    = 8'd255;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TILE_COL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_ROW = 1'b1;

  // cell commands
  typedef enum logic [1:0] {
    CMD_TRANSFER = 2'd0,
    CMD_CAPTURE  = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_e;

  // per-cell operation carried down the pipeline
  typedef struct packed {
    cmd_e                cmd;
    logic                hit;
    logic [HEIGHT_W-1:0] tval;
    logic                src_nz;
    logic [Z_W-1:0]      z;
    logic                force_w;
    logic                last;
  } op_t;

  // pipeline advance controls
  typedef struct packed {
    logic ld_s1;
    logic ld_s2;
    logic fire_s2;
  } flow_t;

  // one result item
  typedef struct packed {
    logic [CAP_W-1:0] captured;
    logic             capture_valid;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/hmsc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module hmsc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write and one registered read per cycle, read returns old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/hmsc_addr.sv
`timescale 1ns / 1ps
`default_nettype none

module hmsc_addr #(
  parameter int unsigned MAP_WIDTH  = 64,
  parameter int unsigned MAP_HEIGHT = 64,
  localparam int unsigned AW = $clog2(MAP_WIDTH * MAP_HEIGHT)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire hmsc_pkg::flow_t                     flow_i,
  input  wire logic                                in_valid_i,
  input  wire logic [hmsc_pkg::TILE_W-1:0]         tile_col_i,
  input  wire logic [hmsc_pkg::TILE_W-1:0]         tile_row_i,
  input  wire logic [1:0]                          cmd_i,
  input  wire logic signed [hmsc_pkg::COORD_W-1:0] cell_x_i,
  input  wire logic signed [hmsc_pkg::COORD_W-1:0] cell_y_i,
  input  wire logic [hmsc_pkg::SRC_W-1:0]          src_i,
  input  wire logic [hmsc_pkg::Z_W-1:0]            z_i,
  input  wire logic                                force_i,
  input  wire logic                                last_i,
  output logic                                     valid_o,
  output logic [AW-1:0]                            addr_o,
  output hmsc_pkg::op_t                            op_o
);

  localparam int unsigned XW  = $clog2(MAP_WIDTH);
  localparam int unsigned YW  = $clog2(MAP_HEIGHT);
  localparam int unsigned OXW = hmsc_pkg::TILE_W + XW;
  localparam int unsigned OYW = hmsc_pkg::TILE_W + YW;
  localparam int unsigned MXW = (OXW > hmsc_pkg::COORD_W) ? OXW : hmsc_pkg::COORD_W;
  localparam int unsigned MYW = (OYW > hmsc_pkg::COORD_W) ? OYW : hmsc_pkg::COORD_W;
  localparam int unsigned RXW = MXW + 2;
  localparam int unsigned RYW = MYW + 2;
  localparam int unsigned TSW = hmsc_pkg::Z_W + 1;

  logic [OXW-1:0]                  origin_x;
  logic [OYW-1:0]                  origin_y;
  logic [RXW-1:0]                  rx_d, rx_q;
  logic [RYW-1:0]                  ry_d, ry_q;
  logic [TSW-1:0]                  tsum;
  logic [hmsc_pkg::HEIGHT_W-1:0]   tval_d, tval_q;
  logic                            valid_d, valid_q;
  hmsc_pkg::cmd_e                  cmd_q;
  logic                            src_nz_q;
  logic [hmsc_pkg::Z_W-1:0]        z_q;
  logic                            force_q;
  logic                            last_q;
  logic                            x_in, y_in;

  // tile origin and cell position relative to it
  assign origin_x = OXW'(tile_col_i) * OXW'(MAP_WIDTH);
  assign origin_y = OYW'(tile_row_i) * OYW'(MAP_HEIGHT);
  assign rx_d     = RXW'(cell_x_i) - RXW'(origin_x);
  assign ry_d     = RYW'(cell_y_i) - RYW'(origin_y);

  // transfer value: source plus offset, saturated to 1..max
  assign tsum = {{(TSW - hmsc_pkg::SRC_W){1'b0}}, src_i} + {z_i[hmsc_pkg::Z_W-1], z_i};

  always_comb begin
    if (tsum[TSW-1] || (tsum == '0)) begin
      tval_d = hmsc_pkg::HEIGHT_W'(1);
    end else if (tsum[hmsc_pkg::HEIGHT_W]) begin
      tval_d = hmsc_pkg::HEIGHT_MAX;
    end else begin
      tval_d = tsum[hmsc_pkg::HEIGHT_W-1:0];
    end
  end

  assign valid_d = flow_i.ld_s1 ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (flow_i.ld_s1) begin
      rx_q     <= rx_d;
      ry_q     <= ry_d;
      tval_q   <= tval_d;
      cmd_q    <= hmsc_pkg::cmd_e'(cmd_i);
      src_nz_q <= (src_i != '0);
      z_q      <= z_i;
      force_q  <= force_i;
      last_q   <= last_i;
    end
  end

  // clipping against the tile
  assign x_in = !rx_q[RXW-1] && (rx_q[RXW-2:0] < (RXW-1)'(MAP_WIDTH));
  assign y_in = !ry_q[RYW-1] && (ry_q[RYW-2:0] < (RYW-1)'(MAP_HEIGHT));

  // row-major store address
  assign addr_o = AW'(ry_q[YW-1:0]) * AW'(MAP_WIDTH) + AW'(rx_q[XW-1:0]);

  assign valid_o = valid_q;
  assign op_o = '{
    cmd:     cmd_q,
    hit:     x_in && y_in,
    tval:    tval_q,
    src_nz:  src_nz_q,
    z:       z_q,
    force_w: force_q,
    last:    last_q
  };

endmodule

`default_nettype wire

>>> hw/rtl/hmsc_rmw.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hmsc_rmw #(
  parameter int unsigned ADDR_W = 12
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire hmsc_pkg::flow_t                     flow_i,
  input  wire logic                                s1_valid_i,
  input  wire logic [ADDR_W-1:0]                   s1_addr_i,
  input  wire hmsc_pkg::op_t                       s1_op_i,
  input  wire logic [hmsc_pkg::HEIGHT_W-1:0]       rdata_i,
  output logic                                     valid_o,
  output logic                                     we_o,
  output logic [ADDR_W-1:0]                        waddr_o,
  output logic [hmsc_pkg::HEIGHT_W-1:0]            wdata_o,
  output hmsc_pkg::res_t                           res_o
);

  localparam int unsigned DW = hmsc_pkg::Z_W + 2;

  logic                          valid_d, valid_q;
  logic [ADDR_W-1:0]             addr_q;
  hmsc_pkg::op_t                 op_q;
  logic                          fwd_d, fwd_q;
  logic [hmsc_pkg::HEIGHT_W-1:0] fwd_data_q;
  logic [hmsc_pkg::HEIGHT_W-1:0] cur;
  logic [DW-1:0]                 diff;
  logic [hmsc_pkg::CAP_W-1:0]    cap;
  logic                          wr_req;
  logic [hmsc_pkg::HEIGHT_W-1:0] wval;
  logic                          is_capture;

  // stored value, with the write of the item ahead forwarded
  assign cur = fwd_q ? fwd_data_q : rdata_i;

  // captured value: stored minus offset, saturated to 1..255, empty reads 0
  assign diff = {{(DW - hmsc_pkg::HEIGHT_W){1'b0}}, cur}
              - {{2{op_q.z[hmsc_pkg::Z_W-1]}}, op_q.z};

  always_comb begin
    if (cur == '0) begin
      cap = '0;
    end else if (diff[DW-1] || (diff == '0)) begin
      cap = hmsc_pkg::CAP_W'(1);
    end else if (|diff[DW-2:hmsc_pkg::CAP_W]) begin
      cap = hmsc_pkg::CAP_MAX;
    end else begin
      cap = diff[hmsc_pkg::CAP_W-1:0];
    end
  end

  // command decode
  always_comb begin
    wr_req     = 1'b0;
    wval       = '0;
    is_capture = 1'b0;
    case (op_q.cmd)
      hmsc_pkg::CMD_TRANSFER: begin
        wr_req = op_q.src_nz && ((cur < op_q.tval) || op_q.force_w);
        wval   = op_q.tval;
      end
      hmsc_pkg::CMD_CAPTURE: begin
        is_capture = 1'b1;
      end
      hmsc_pkg::CMD_CLEAR: begin
        wr_req = 1'b1;
      end
      default: begin
        wr_req = 1'b0;
      end
    endcase
  end

  // write back as the item leaves the stage
  assign we_o    = valid_q && flow_i.fire_s2 && op_q.hit && wr_req;
  assign waddr_o = addr_q;
  assign wdata_o = wval;

  assign res_o = '{
    captured:      (op_q.hit && is_capture) ? cap : '0,
    capture_valid: op_q.hit && is_capture,
    last:          op_q.last
  };

  assign valid_d = flow_i.ld_s2 ? s1_valid_i : valid_q;
  assign fwd_d   = flow_i.ld_s2 ? (s1_valid_i && we_o && (s1_addr_i == addr_q)) : fwd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      fwd_q   <= fwd_d;
    end
  end

  // stage payload and forwarded data
  always_ff @(posedge clk_i) begin
    if (flow_i.ld_s2) begin
      addr_q     <= s1_addr_i;
      op_q       <= s1_op_i;
      fwd_data_q <= wval;
    end
  end

  assign valid_o = valid_q;

  `HMSC_ASSERT(fwd_needs_item, fwd_q |-> valid_q, "forward flag set without an item")
  `HMSC_ASSERT_NEXT(stall_holds_entry, valid_q && !flow_i.ld_s2,
                    $stable(addr_q) && $stable(fwd_q), "stalled entry changed")

endmodule

`default_nettype wire

>>> hw/rtl/height_map_stamp_capture_core.sv
// Height map stamp capture core: a 16-bit height store for one tile of a grid.
// Input stream: one source cell per transaction. tuser carries the command,
// tdata the cell coordinates, source height, offset and force flag, and tlast
// marks the last cell of a rectangle. Output stream: one result per input,
// tdata the captured byte, tuser the capture-valid flag, tlast the copy of
// the input tlast. Cells outside the tile leave the store unchanged.
// Throughput is one cell per cycle unless the output stalls or the clearing
// sweep runs: the store is a single memory with one registered read and one
// write per cycle, and the stored value is forwarded when a cell hits the
// entry written by the cell just ahead of it. A cell passes the address stage,
// the read-modify-write stage and the output register. After reset the core
// sweeps all MAP_WIDTH*MAP_HEIGHT entries (4096 at the defaults) to zero,
// with s_axis_tready low; tile register writes on the cfg port are taken at
// any time. A stalled output holds its result; the stages take input until full.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module height_map_stamp_capture_core #(
  parameter int unsigned MAP_WIDTH  = 64,
  parameter int unsigned MAP_HEIGHT = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration writes
  input  wire logic                               cfg_we_i,
  input  wire logic [hmsc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [hmsc_pkg::TILE_W-1:0]        cfg_data_i,
  // input cells
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // cell_x [15:0], cell_y [31:16], source_height [39:32], z_pos [56:40],
  // force_write [57], zero [63:58]
  input  wire logic [hmsc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // command [1:0]
  input  wire logic [1:0]                         s_axis_tuser,
  input  wire logic                               s_axis_tlast,
  // results
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // captured [7:0]
  output logic [hmsc_pkg::CAP_W-1:0]              m_axis_tdata,
  // capture_valid [0]
  output logic                                    m_axis_tuser,
  output logic                                    m_axis_tlast
);

  localparam int unsigned DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [hmsc_pkg::TILE_W-1:0]   tile_col_d, tile_col_q;
  logic [hmsc_pkg::TILE_W-1:0]   tile_row_d, tile_row_q;
  logic                          clearing_d, clearing_q;
  logic [AW-1:0]                 clr_addr_d, clr_addr_q;
  logic                          out_valid_d, out_valid_q;
  hmsc_pkg::res_t                out_res_q;
  hmsc_pkg::flow_t               flow;
  logic                          out_en;
  logic                          s1_valid, s2_valid;
  logic [AW-1:0]                 s1_addr;
  hmsc_pkg::op_t                 s1_op;
  logic [hmsc_pkg::HEIGHT_W-1:0] rdata;
  logic                          upd_we;
  logic [AW-1:0]                 upd_addr;
  logic [hmsc_pkg::HEIGHT_W-1:0] upd_data;
  hmsc_pkg::res_t                s2_res;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [hmsc_pkg::HEIGHT_W-1:0] ram_wdata;

  // tile registers
  always_comb begin
    tile_col_d = tile_col_q;
    tile_row_d = tile_row_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        hmsc_pkg::REG_TILE_COL: tile_col_d = cfg_data_i;
        hmsc_pkg::REG_TILE_ROW: tile_row_d = cfg_data_i;
        default: begin
          tile_col_d = tile_col_q;
        end
      endcase
    end
  end

  // clearing sweep after reset
  assign clearing_d = clearing_q && (clr_addr_q != AW'(DEPTH - 1));
  assign clr_addr_d = clearing_q ? clr_addr_q + AW'(1) : clr_addr_q;

  // stage advance: a stage loads when it is empty or its content moves on
  assign out_en        = !out_valid_q || m_axis_tready;
  assign flow.fire_s2  = s2_valid && out_en;
  assign flow.ld_s2    = !s2_valid || out_en;
  assign flow.ld_s1    = !s1_valid || flow.ld_s2;
  assign s_axis_tready = flow.ld_s1 && !clearing_q;

  assign out_valid_d = out_en ? s2_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_col_q  <= '0;
      tile_row_q  <= '0;
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tile_col_q  <= tile_col_d;
      tile_row_q  <= tile_row_d;
      clearing_q  <= clearing_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_res_q <= s2_res;
    end
  end

  // address and clipping stage
  hmsc_addr #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT)
  ) u_addr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flow_i     (flow),
    .in_valid_i (s_axis_tvalid && s_axis_tready),
    .tile_col_i (tile_col_q),
    .tile_row_i (tile_row_q),
    .cmd_i      (s_axis_tuser),
    .cell_x_i   (s_axis_tdata[15:0]),
    .cell_y_i   (s_axis_tdata[31:16]),
    .src_i      (s_axis_tdata[39:32]),
    .z_i        (s_axis_tdata[56:40]),
    .force_i    (s_axis_tdata[57]),
    .last_i     (s_axis_tlast),
    .valid_o    (s1_valid),
    .addr_o     (s1_addr),
    .op_o       (s1_op)
  );

  // read-modify-write stage
  hmsc_rmw #(
    .ADDR_W (AW)
  ) u_rmw (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flow_i     (flow),
    .s1_valid_i (s1_valid),
    .s1_addr_i  (s1_addr),
    .s1_op_i    (s1_op),
    .rdata_i    (rdata),
    .valid_o    (s2_valid),
    .we_o       (upd_we),
    .waddr_o    (upd_addr),
    .wdata_o    (upd_data),
    .res_o      (s2_res)
  );

  // write port shared between the clearing sweep and the update stage
  assign ram_we    = clearing_q || upd_we;
  assign ram_waddr = clearing_q ? clr_addr_q : upd_addr;
  assign ram_wdata = clearing_q ? '0 : upd_data;

  hmsc_ram #(
    .WIDTH (hmsc_pkg::HEIGHT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (flow.ld_s2),
    .raddr_i (s1_addr),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q.captured;
  assign m_axis_tuser  = out_res_q.capture_valid;
  assign m_axis_tlast  = out_res_q.last;

  `HMSC_ASSERT(no_update_while_clearing, clearing_q |-> !upd_we,
               "cell update during clearing sweep")
  `HMSC_ASSERT_NEXT(clear_runs_once, !clearing_q, !clearing_q,
                    "clearing sweep restarted")

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int MAP_W = 64;
  localparam int MAP_H = 64;
  localparam int MAP_CELLS = MAP_W * MAP_H;
  // unused command code, not a member of cmd_e
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // cycles without any transaction before giving up (covers the reset sweep)
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_CELLS = 172;
  localparam int PRINT_LIMIT = 40;

  // one source cell as the block sees it
  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         src;
    logic signed [16:0] z;
    logic               force_w;
    logic               last;
  } cell_t;

  // height map mirror and queue of expected results
  class tile_height_board;
    logic [hmsc_pkg::HEIGHT_W-1:0] heights [MAP_CELLS];
    hmsc_pkg::res_t pending_results[$];
    int tile_col;
    int tile_row;
    int errors;
    int checked;
    int cells;
    int captures;
    int clipped;
    int writes;

    function new();
      foreach (heights[i]) heights[i] = '0;
      tile_col = 0;
      tile_row = 0;
    endfunction

    function void set_tile(int col, int row);
      tile_col = col;
      tile_row = row;
    endfunction

    function int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // apply one accepted cell to the mirror and queue its result
    function void note_cell(cell_t c);
      int xv;
      int yv;
      int zv;
      int rx;
      int ry;
      int idx;
      int curv;
      int v;
      hmsc_pkg::res_t r;
      xv = c.x;
      yv = c.y;
      zv = c.z;
      rx = xv - tile_col * MAP_W;
      ry = yv - tile_row * MAP_H;
      r = '0;
      r.last = c.last;
      cells++;
      if (rx >= 0 && rx < MAP_W && ry >= 0 && ry < MAP_H) begin
        idx = ry * MAP_W + rx;
        curv = heights[idx];
        case (c.cmd)
          hmsc_pkg::CMD_TRANSFER: begin
            if (c.src != 0) begin
              v = clamp(int'(c.src) + zv, 1, int'(hmsc_pkg::HEIGHT_MAX));
              if (curv < v || c.force_w) begin
                heights[idx] = v[hmsc_pkg::HEIGHT_W-1:0];
                writes++;
              end
            end
          end
          hmsc_pkg::CMD_CAPTURE: begin
            v = (curv == 0) ? 0 : clamp(curv - zv, 1, int'(hmsc_pkg::CAP_MAX));
            r.captured = v[hmsc_pkg::CAP_W-1:0];
            r.capture_valid = 1'b1;
            captures++;
          end
          hmsc_pkg::CMD_CLEAR: begin
            heights[idx] = '0;
          end
          default: begin
          end
        endcase
      end else begin
        clipped++;
      end
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // compare one result transaction with the oldest expectation
    task check_result(hmsc_pkg::res_t got);
      hmsc_pkg::res_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (got.captured !== want.captured)
          report_mismatch("captured", got.captured, want.captured);
        if (got.capture_valid !== want.capture_valid)
          report_mismatch("capture_valid", got.capture_valid, want.capture_valid);
        if (got.last !== want.last)
          report_mismatch("last", got.last, want.last);
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [hmsc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [hmsc_pkg::TILE_W-1:0] cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [hmsc_pkg::IN_DATA_W-1:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [hmsc_pkg::CAP_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  tile_height_board board = new();
  int cur_col;
  int cur_row;
  int tile_settings;
  int quiet_cycles;
  bit steady;
  bit hold_off_req;

  always #10 clk_i = ~clk_i;

  height_map_stamp_capture_core #(
    .MAP_WIDTH (MAP_W),
    .MAP_HEIGHT(MAP_H)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // result monitor
  always @(posedge clk_i) begin : result_monitor
    hmsc_pkg::res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.captured = m_axis_tdata;
      got.capture_valid = m_axis_tuser;
      got.last = m_axis_tlast;
      board.check_result(got);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d cycles with no transaction", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result receiver: random stalls, one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  function automatic cell_t make_cell(logic [1:0] cmd, int x, int y, int src, int z,
                                      bit force_w, bit last);
    cell_t c;
    c.cmd = cmd;
    c.x = x[15:0];
    c.y = y[15:0];
    c.src = src[7:0];
    c.z = z[16:0];
    c.force_w = force_w;
    c.last = last;
    return c;
  endfunction

  // random cell, mostly inside the current tile and on a few hot cells
  function automatic cell_t random_cell();
    cell_t c;
    int pick;
    int rx;
    int ry;
    int tmp;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      rx = $urandom_range(0, 3);
      ry = $urandom_range(0, 1);
    end else if (pick < 70) begin
      rx = $urandom_range(0, MAP_W - 1);
      ry = $urandom_range(0, MAP_H - 1);
    end else begin
      rx = $urandom_range(0, MAP_W + 5);
      ry = $urandom_range(0, MAP_H + 5);
      rx = rx - 3;
      ry = ry - 3;
    end
    if (pick < 88) begin
      tmp = cur_col * MAP_W + rx;
      c.x = tmp[15:0];
      tmp = cur_row * MAP_H + ry;
      c.y = tmp[15:0];
    end else begin
      c.x = 16'($urandom);
      c.y = 16'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 45) c.cmd = hmsc_pkg::CMD_TRANSFER;
    else if (pick < 80) c.cmd = hmsc_pkg::CMD_CAPTURE;
    else if (pick < 92) c.cmd = hmsc_pkg::CMD_CLEAR;
    else c.cmd = CMD_UNUSED;
    pick = $urandom_range(0, 9);
    if (pick == 0) c.src = 8'd0;
    else if (pick == 1) c.src = 8'hff;
    else c.src = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      c.z = 17'($urandom);
    end else if (pick < 25) begin
      c.z = $urandom_range(0, 1) ? 17'h0ffff : 17'h10000;
    end else begin
      tmp = $urandom_range(0, 600);
      tmp = tmp - 300;
      c.z = tmp[16:0];
    end
    c.force_w = ($urandom_range(0, 3) == 0);
    c.last = ($urandom_range(0, 7) == 0);
    return c;
  endfunction

  // offer one cell and wait for its transaction
  task automatic send_cell(input cell_t c);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, c.force_w, c.z, c.src, c.y, c.x};
    s_axis_tuser <= c.cmd;
    s_axis_tlast <= c.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_cell(c);
  endtask

  task automatic pause_input(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // stop offering until every expected result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [hmsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hmsc_pkg::TILE_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_tile(input logic [hmsc_pkg::TILE_W-1:0] col,
                          input logic [hmsc_pkg::TILE_W-1:0] row);
    drain_results();
    write_reg(hmsc_pkg::REG_TILE_COL, col);
    write_reg(hmsc_pkg::REG_TILE_ROW, row);
    cur_col = col;
    cur_row = row;
    board.set_tile(cur_col, cur_row);
    tile_settings++;
  endtask

  // random phase; pressure 1 asks a receiver hold-off, 2 a full drain midway
  task automatic run_phase(input logic [hmsc_pkg::TILE_W-1:0] col,
                           input logic [hmsc_pkg::TILE_W-1:0] row,
                           input bit quiet_run, input int pressure);
    set_tile(col, row);
    steady = quiet_run;
    for (int i = 0; i < PHASE_CELLS; i++) begin
      if (i == PHASE_CELLS / 2) begin
        if (pressure == 1) hold_off_req = 1'b1;
        if (pressure == 2) drain_results();
      end
      if (!steady && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 6));
      send_cell(random_cell());
    end
  endtask

  // main stimulus
  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= hmsc_pkg::REG_TILE_COL;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= hmsc_pkg::CMD_TRANSFER;
    s_axis_tlast <= 1'b0;
    steady = 1'b0;
    hold_off_req = 1'b0;
    quiet_cycles = 0;
    tile_settings = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed cells on tile origin, back to back
    set_tile(6'd0, 6'd0);
    send_cell(make_cell(hmsc_pkg::CMD_CAPTURE, 0, 0, 0, 0, 0, 0));         // empty cell
    send_cell(make_cell(hmsc_pkg::CMD_TRANSFER, 0, 0, 255, 65535, 0, 0));  // saturates high
    send_cell(make_cell(hmsc_pkg::CMD_CAPTURE, 0, 0, 0, -65536, 0, 0));    // capture high
    send_cell(make_cell(hmsc_pkg::CMD_CAPTURE, 0, 0, 0, 65535, 0, 0));     // capture low
    send_cell(make_cell(hmsc_pkg::CMD_TRANSFER, 0, 0, 10, 0, 0, 0));       // lower, kept
    send_cell(make_cell(hmsc_pkg::CMD_CAPTURE, 0, 0, 0, 0, 0, 0));
    send_cell(make_cell(hmsc_pkg::CMD_TRANSFER, 0, 0, 10, 0, 1, 0));       // forced write
    send_cell(make_cell(hmsc_pkg::CMD_CAPTURE, 0, 0, 0, 0, 0, 0));
    send_cell(make_cell(hmsc_pkg::CMD_TRANSFER, 63, 63, 1, -65536, 0, 0)); // saturates low
    send_cell(make_cell(hmsc_pkg::CMD_CAPTURE, 63, 63, 0, 0, 0, 0));
    send_cell(make_cell(hmsc_pkg::CMD_TRANSFER, 1, 0, 0, 500, 1, 0));      // zero height
    send_cell(make_cell(hmsc_pkg::CMD_CAPTURE, 1, 0, 0, 0, 0, 0));
    send_cell(make_cell(hmsc_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    send_cell(make_cell(hmsc_pkg::CMD_CAPTURE, 0, 0, 0, 0, 0, 0));
    send_cell(make_cell(CMD_UNUSED, 5, 5, 200, 0, 1, 0));                  // unused command
    send_cell(make_cell(hmsc_pkg::CMD_CAPTURE, 5, 5, 0, 0, 0, 0));
    send_cell(make_cell(hmsc_pkg::CMD_TRANSFER, -1, 0, 200, 0, 1, 0));     // clipped cells
    send_cell(make_cell(hmsc_pkg::CMD_TRANSFER, 64, 0, 200, 0, 1, 0));
    send_cell(make_cell(hmsc_pkg::CMD_CAPTURE, 0, 64, 0, 0, 0, 0));
    send_cell(make_cell(hmsc_pkg::CMD_CAPTURE, -32768, 32767, 0, 0, 0, 1));
    send_cell(make_cell(hmsc_pkg::CMD_TRANSFER, 63, 0, 255, 0, 0, 0));
    send_cell(make_cell(hmsc_pkg::CMD_TRANSFER, 63, 0, 100, 0, 0, 0));
    send_cell(make_cell(hmsc_pkg::CMD_CAPTURE, 63, 0, 0, 0, 0, 1));
    send_cell(make_cell(hmsc_pkg::CMD_TRANSFER, 0, 63, 255, -100, 0, 0));
    send_cell(make_cell(hmsc_pkg::CMD_CAPTURE, 0, 63, 0, -100, 0, 1));

    // random phases over corner and random tiles, steady at the end
    run_phase(6'd63, 6'd63, 1'b0, 1);
    run_phase(6'd63, 6'd0, 1'b0, 2);
    run_phase(6'd0, 6'd63, 1'b0, 0);
    run_phase(6'($urandom), 6'($urandom), 1'b0, 1);
    run_phase(6'($urandom), 6'($urandom), 1'b0, 0);
    run_phase(6'd0, 6'd0, 1'b1, 0);
    drain_results();

    $display("covered %0d cells over %0d tile settings, %0d results checked",
             board.cells, tile_settings, board.checked);
    $display("%0d in-tile captures, %0d clipped cells, %0d height writes",
             board.captures, board.clipped, board.writes);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
